// ===== sv/c3d_pkg.sv =====
// ============================================================================
// c3d_pkg: shared constants of the three-body state derivative core
// Register indexes, register widths and register reset values.
// ============================================================================
`default_nettype none

package c3d_pkg;

    localparam int REG_FRAC      = 24;  // fraction bits of the register values
    localparam int MU_BITS       = 24;
    localparam int PX_BITS       = 32;
    localparam int CFG_IDX_BITS  = 8;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [CFG_IDX_BITS-1:0] CFG_MASS_RATIO    = 8'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PRIMARY_ONE_X = 8'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PRIMARY_TWO_X = 8'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPATIAL_MODE  = 8'd3;

    localparam logic [MU_BITS-1:0] MU_RST = 24'd203843;
    localparam logic [PX_BITS-1:0] P1_RST = 32'hFFFC_E3BD;  // minus the mass ratio
    localparam logic [PX_BITS-1:0] P2_RST = 32'd16573373;
    localparam logic               SP_RST = 1'b1;

endpackage

`default_nettype wire

// ===== sv/cr3bp_state_derivative_core.sv =====
// ============================================================================
// cr3bp_state_derivative_core: rotating-frame three-body state derivative
// Velocity, acceleration, pseudo-potential and Jacobi constant of one state.
// ============================================================================
// Usage:
//   Drive the six state words and raise start; the state is taken at a clock
//   edge with start high and busy low. One state can be taken every cycle while busy is low.
//   Each result is shown for exactly one cycle with o_done high; the receiver
//   must capture it then, results are never held back.
//   Each state passes through the bit-per-stage square root (WORD_BITS stages)
//   followed by the bit-per-stage reciprocal dividers (WORD_BITS-1 stages).
//   Throughput is one state per cycle while busy is low.
//   A four-entry queue sits between intake and the arithmetic pipeline;
//   busy rises only when it is full.
//   Registers are written through the cfg channel (index, data), which is
//   always ready; write them only while no state is in flight.
//   Reset (synchronous, active low) empties the queue and pipeline and loads
//   the default mass ratio, primary positions and spatial mode.
// ============================================================================
`default_nettype none

module cr3bp_state_derivative_core
    import c3d_pkg::*;
#(
    parameter int FRAC_BITS = 24,
    parameter int WORD_BITS = 32
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic signed [WORD_BITS-1:0] i_pos_x,
    input  wire logic signed [WORD_BITS-1:0] i_pos_y,
    input  wire logic signed [WORD_BITS-1:0] i_pos_z,
    input  wire logic signed [WORD_BITS-1:0] i_vel_x_in,
    input  wire logic signed [WORD_BITS-1:0] i_vel_y_in,
    input  wire logic signed [WORD_BITS-1:0] i_vel_z_in,
    output logic                             o_done,
    output logic signed [WORD_BITS-1:0]      o_dpos_x,
    output logic signed [WORD_BITS-1:0]      o_dpos_y,
    output logic signed [WORD_BITS-1:0]      o_dpos_z,
    output logic signed [WORD_BITS-1:0]      o_accel_x,
    output logic signed [WORD_BITS-1:0]      o_accel_y,
    output logic signed [WORD_BITS-1:0]      o_accel_z,
    output logic signed [WORD_BITS-1:0]      o_effective_potential,
    output logic signed [WORD_BITS-1:0]      o_jacobi_constant,
    output logic                             o_near_singular,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0]     i_cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]    i_cfg_data
);

    logic [MU_BITS-1:0] r_mass_ratio;
    logic [PX_BITS-1:0] r_primary_one_x;
    logic [PX_BITS-1:0] r_primary_two_x;
    logic               r_spatial_mode;

    logic                   s_q_valid;
    logic                   s_q_pop;
    logic [10*WORD_BITS:0]  s_q_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mass_ratio    <= MU_RST;
            r_primary_one_x <= P1_RST;
            r_primary_two_x <= P2_RST;
            r_spatial_mode  <= SP_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_MASS_RATIO:    r_mass_ratio    <= i_cfg_data[MU_BITS-1:0];
                CFG_PRIMARY_ONE_X: r_primary_one_x <= i_cfg_data[PX_BITS-1:0];
                CFG_PRIMARY_TWO_X: r_primary_two_x <= i_cfg_data[PX_BITS-1:0];
                CFG_SPATIAL_MODE:  r_spatial_mode  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    c3d_front #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .o_busy         (busy),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_pos_z        (i_pos_z),
        .i_vel_x_in     (i_vel_x_in),
        .i_vel_y_in     (i_vel_y_in),
        .i_vel_z_in     (i_vel_z_in),
        .i_mass_ratio   (r_mass_ratio),
        .i_primary_one_x(r_primary_one_x),
        .i_primary_two_x(r_primary_two_x),
        .i_spatial_mode (r_spatial_mode),
        .o_q_valid      (s_q_valid),
        .o_q_data       (s_q_data),
        .i_q_pop        (s_q_pop)
    );

    c3d_back #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_q_valid            (s_q_valid),
        .i_q_data             (s_q_data),
        .o_q_pop              (s_q_pop),
        .o_done               (o_done),
        .o_dpos_x             (o_dpos_x),
        .o_dpos_y             (o_dpos_y),
        .o_dpos_z             (o_dpos_z),
        .o_accel_x            (o_accel_x),
        .o_accel_y            (o_accel_y),
        .o_accel_z            (o_accel_z),
        .o_effective_potential(o_effective_potential),
        .o_jacobi_constant    (o_jacobi_constant),
        .o_near_singular      (o_near_singular)
    );

endmodule

`default_nettype wire

// ===== sv/c3d_delay.sv =====
// ============================================================================
// c3d_delay: fixed-depth register delay line
// Keeps side data aligned with the square-root and divider pipelines.
// ============================================================================
`default_nettype none

module c3d_delay #(
    parameter int DATA_BITS = 8,
    parameter int DEPTH     = 4
) (
    input  wire logic                 i_clk,
    input  wire logic [DATA_BITS-1:0] i_data,
    output logic      [DATA_BITS-1:0] o_data
);

    logic [DATA_BITS-1:0] r_pipe [DEPTH];

    always_ff @(posedge i_clk) begin
        r_pipe[0] <= i_data;
        for (int i = 1; i < DEPTH; i++) begin
            r_pipe[i] <= r_pipe[i-1];
        end
    end

    assign o_data = r_pipe[DEPTH-1];

endmodule

`default_nettype wire

// ===== sv/c3d_isqrt.sv =====
// ============================================================================
// c3d_isqrt: pipelined integer square root
// One root bit per stage, WORD_BITS stages, floor of the square root.
// ============================================================================
`default_nettype none

module c3d_isqrt #(
    parameter int WORD_BITS = 32
) (
    input  wire logic                   i_clk,
    input  wire logic [2*WORD_BITS-1:0] i_rad,
    output logic      [WORD_BITS-1:0]   o_root
);

    localparam int W  = WORD_BITS;
    localparam int RW = 2 * W + 1;

    logic [RW-1:0] r_rem  [W];
    logic [W-1:0]  r_root [W];

    for (genvar j = 0; j < W; j++) begin : g_stage
        localparam int K = W - 1 - j;
        logic [RW-1:0] rem_in;
        logic [W-1:0]  root_in;
        logic [RW-1:0] trial;

        if (j == 0) begin : g_first
            assign rem_in  = RW'(i_rad);
            assign root_in = '0;
        end else begin : g_next
            assign rem_in  = r_rem[j-1];
            assign root_in = r_root[j-1];
        end

        // (root + 2^k)^2 - root^2 with root holding only bits above k
        assign trial = (RW'(root_in) << (K + 1)) | (RW'(1) << (2 * K));

        always_ff @(posedge i_clk) begin
            if (rem_in >= trial) begin
                r_rem[j]  <= rem_in - trial;
                r_root[j] <= root_in | (W'(1) << K);
            end else begin
                r_rem[j]  <= rem_in;
                r_root[j] <= root_in;
            end
        end
    end

    assign o_root = r_root[W-1];

endmodule

`default_nettype wire

// ===== sv/c3d_recip.sv =====
// ============================================================================
// c3d_recip: pipelined power-of-two reciprocal
// floor(2^NUM_EXP / den), one quotient bit per stage, clamped to the largest
// word with a flag on zero or on a quotient that does not fit.
// ============================================================================
`default_nettype none

module c3d_recip #(
    parameter int WORD_BITS = 32,
    parameter int NUM_EXP   = 48,
    parameter int DEN_BITS  = 32
) (
    input  wire logic                 i_clk,
    input  wire logic [DEN_BITS-1:0]  i_den,
    output logic      [WORD_BITS-2:0] o_quo,
    output logic                      o_clamp
);

    localparam int QB  = WORD_BITS - 1;
    localparam int RA  = NUM_EXP + 1;
    localparam int RB  = DEN_BITS + QB;
    localparam int RW  = ((RA > RB) ? RA : RB) + 1;
    localparam bit HAS_THR = (NUM_EXP >= QB);
    localparam int TSH = HAS_THR ? (NUM_EXP - QB) : 0;
    localparam logic [RW-1:0] THR = RW'(1) << TSH;
    localparam logic [RW-1:0] NUM = RW'(1) << NUM_EXP;

    logic [RW-1:0]       r_rem [QB];
    logic [DEN_BITS-1:0] r_den [QB];
    logic [QB-1:0]       r_quo [QB];
    logic                r_ovf [QB];
    logic                s_ovf;

    // quotient >= 2^QB exactly when den <= 2^(NUM_EXP-QB)
    assign s_ovf = (i_den == '0) || (HAS_THR && (RW'(i_den) <= THR));

    for (genvar j = 0; j < QB; j++) begin : g_stage
        localparam int BIT = QB - 1 - j;
        logic [RW-1:0]       rem_in;
        logic [DEN_BITS-1:0] den_in;
        logic [QB-1:0]       quo_in;
        logic                ovf_in;
        logic [RW-1:0]       trial;

        if (j == 0) begin : g_first
            assign rem_in = NUM;
            assign den_in = i_den;
            assign quo_in = '0;
            assign ovf_in = s_ovf;
        end else begin : g_next
            assign rem_in = r_rem[j-1];
            assign den_in = r_den[j-1];
            assign quo_in = r_quo[j-1];
            assign ovf_in = r_ovf[j-1];
        end

        assign trial = RW'(den_in) << BIT;

        always_ff @(posedge i_clk) begin
            if (rem_in >= trial) begin
                r_rem[j] <= rem_in - trial;
                r_quo[j] <= quo_in | (QB'(1) << BIT);
            end else begin
                r_rem[j] <= rem_in;
                r_quo[j] <= quo_in;
            end
            r_den[j] <= den_in;
            r_ovf[j] <= ovf_in;
        end
    end

    assign o_quo   = r_ovf[QB-1] ? '1 : r_quo[QB-1];
    assign o_clamp = r_ovf[QB-1];

endmodule

`default_nettype wire

// ===== sv/c3d_front.sv =====
// ============================================================================
// c3d_front: item intake and preparation
// Rescales the registers, applies planar mode, forms the primary offsets and
// queues the prepared item for the arithmetic pipeline.
// ============================================================================
`default_nettype none

module c3d_front
    import c3d_pkg::*;
#(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 24
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    output logic                             o_busy,
    input  wire logic signed [WORD_BITS-1:0] i_pos_x,
    input  wire logic signed [WORD_BITS-1:0] i_pos_y,
    input  wire logic signed [WORD_BITS-1:0] i_pos_z,
    input  wire logic signed [WORD_BITS-1:0] i_vel_x_in,
    input  wire logic signed [WORD_BITS-1:0] i_vel_y_in,
    input  wire logic signed [WORD_BITS-1:0] i_vel_z_in,
    input  wire logic [MU_BITS-1:0]          i_mass_ratio,
    input  wire logic [PX_BITS-1:0]          i_primary_one_x,
    input  wire logic [PX_BITS-1:0]          i_primary_two_x,
    input  wire logic                        i_spatial_mode,
    output logic                             o_q_valid,
    output logic [10*WORD_BITS:0]            o_q_data,
    input  wire logic                        i_q_pop
);

    localparam int W   = WORD_BITS;
    localparam int F   = FRAC_BITS;
    localparam int EW  = W + 44;
    localparam int LSH = (F >= REG_FRAC) ? (F - REG_FRAC) : 0;
    localparam int RSH = (F <  REG_FRAC) ? (REG_FRAC - F) : 0;
    localparam int QD  = 4;
    localparam int QA  = $clog2(QD);

    localparam logic signed [EW-1:0] SMAX_E = {{(EW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [EW-1:0] SMIN_E = ~SMAX_E;
    localparam logic signed [EW-1:0] ONE_E  = EW'(1) <<< F;

    typedef struct packed {
        logic signed [W-1:0] x;
        logic signed [W-1:0] y;
        logic signed [W-1:0] z;
        logic signed [W-1:0] vx;
        logic signed [W-1:0] vy;
        logic signed [W-1:0] vz;
        logic signed [W-1:0] dx1;
        logic signed [W-1:0] dx2;
        logic signed [W-1:0] mu;
        logic signed [W-1:0] om;
        logic                sp;
    } t_item;

    function automatic logic signed [W-1:0] sat_e(input logic signed [EW-1:0] v);
        if (v > SMAX_E) begin
            return SMAX_E[W-1:0];
        end else if (v < SMIN_E) begin
            return SMIN_E[W-1:0];
        end
        return v[W-1:0];
    endfunction

    // left shift is exact, arithmetic right shift floors
    function automatic logic signed [W-1:0] rescale(input logic signed [EW-1:0] v);
        return sat_e((v <<< LSH) >>> RSH);
    endfunction

    logic signed [W-1:0] s_mu;
    logic signed [W-1:0] s_p1;
    logic signed [W-1:0] s_p2;
    t_item               s_item;
    logic                s_push;

    logic [$bits(t_item)-1:0] r_q_mem [QD];
    logic [QA-1:0]            r_wp;
    logic [QA-1:0]            r_rp;
    logic [QA:0]              r_cnt;
    logic [QA:0]              n_cnt;

    always_comb begin
        s_mu = rescale(EW'($signed({1'b0, i_mass_ratio})));
        s_p1 = rescale(EW'($signed(i_primary_one_x)));
        s_p2 = rescale(EW'($signed(i_primary_two_x)));

        s_item.sp  = i_spatial_mode;
        s_item.x   = i_pos_x;
        s_item.y   = i_pos_y;
        s_item.z   = i_spatial_mode ? i_pos_z : '0;
        s_item.vx  = i_vel_x_in;
        s_item.vy  = i_vel_y_in;
        s_item.vz  = i_spatial_mode ? i_vel_z_in : '0;
        s_item.dx1 = sat_e(EW'(i_pos_x) - EW'(s_p1));
        s_item.dx2 = sat_e(EW'(i_pos_x) - EW'(s_p2));
        s_item.mu  = s_mu;
        s_item.om  = sat_e(ONE_E - EW'(s_mu));
    end

    assign o_busy    = (r_cnt == (QA+1)'(QD));
    assign s_push    = i_start && !o_busy;
    assign o_q_valid = (r_cnt != '0);
    assign o_q_data  = r_q_mem[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (s_push && !(i_q_pop && o_q_valid)) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!s_push && i_q_pop && o_q_valid) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (s_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_q_pop && o_q_valid) begin
                r_rp <= r_rp + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_push) begin
            r_q_mem[r_wp] <= s_item;
        end
    end

endmodule

`default_nettype wire

// ===== sv/c3d_back.sv =====
// ============================================================================
// c3d_back: arithmetic pipeline
// Squared distances, roots, reciprocals, gravity terms, sums and saturation.
// Takes one queued item per cycle and never stalls.
// ============================================================================
`default_nettype none

module c3d_back #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 24
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_q_valid,
    input  wire logic [10*WORD_BITS:0]  i_q_data,
    output logic                        o_q_pop,
    output logic                        o_done,
    output logic signed [WORD_BITS-1:0] o_dpos_x,
    output logic signed [WORD_BITS-1:0] o_dpos_y,
    output logic signed [WORD_BITS-1:0] o_dpos_z,
    output logic signed [WORD_BITS-1:0] o_accel_x,
    output logic signed [WORD_BITS-1:0] o_accel_y,
    output logic signed [WORD_BITS-1:0] o_accel_z,
    output logic signed [WORD_BITS-1:0] o_effective_potential,
    output logic signed [WORD_BITS-1:0] o_jacobi_constant,
    output logic                        o_near_singular
);

    localparam int W   = WORD_BITS;
    localparam int F   = FRAC_BITS;
    localparam int QB  = W - 1;
    localparam int MW  = 2 * W + 2;
    localparam int DLY = 2 * W - 1;          // root plus reciprocal stages
    localparam int LAT = 2 + DLY + 6;

    localparam logic signed [W-1:0]  SMAX_W = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0]  SMIN_W = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [MW-1:0] SMAX_M = MW'(SMAX_W);
    localparam logic signed [MW-1:0] SMIN_M = MW'(SMIN_W);

    typedef struct packed {
        logic signed [W-1:0] x;
        logic signed [W-1:0] y;
        logic signed [W-1:0] z;
        logic signed [W-1:0] vx;
        logic signed [W-1:0] vy;
        logic signed [W-1:0] vz;
        logic signed [W-1:0] dx1;
        logic signed [W-1:0] dx2;
        logic signed [W-1:0] mu;
        logic signed [W-1:0] om;
        logic                sp;
    } t_item;

    function automatic logic [W-1:0] mag(input logic signed [W-1:0] v);
        return v[W-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic logic signed [W-1:0] sat_m(input logic signed [MW-1:0] v);
        if (v > SMAX_M) begin
            return SMAX_W;
        end else if (v < SMIN_M) begin
            return SMIN_W;
        end
        return v[W-1:0];
    endfunction

    // product of magnitudes, truncated, sign applied, saturated
    function automatic logic signed [W-1:0] mulq(input logic signed [W-1:0] a,
                                                 input logic signed [W-1:0] b);
        logic [2*W-1:0]         p;
        logic signed [MW-1:0]   v;
        p = (2*W)'(mag(a)) * (2*W)'(mag(b));
        p = p >> F;
        v = $signed({2'b00, p});
        if (a[W-1] != b[W-1]) begin
            v = -v;
        end
        return sat_m(v);
    endfunction

    function automatic logic signed [MW-1:0] ext(input logic signed [W-1:0] v);
        return MW'(v);
    endfunction

    t_item s_head;
    t_item s_r_item;

    logic [LAT-1:0] r_vld;

    // squares
    t_item          r_s0_item;
    logic [2*W-1:0] r_s0_sq1;
    logic [2*W-1:0] r_s0_sq2;
    logic [2*W-1:0] r_s0_sqy;
    logic [2*W-1:0] r_s0_sqz;
    // squared distances
    t_item          r_s1_item;
    logic [2*W-1:0] r_s1_d2a;
    logic [2*W-1:0] r_s1_d2b;

    logic [W-1:0]   s_ra;
    logic [W-1:0]   s_rb;
    logic [4*W-1:0] s_d2_dly;
    logic [QB-1:0]  s_ia1;
    logic [QB-1:0]  s_ib1;
    logic [QB-1:0]  s_ia2;
    logic [QB-1:0]  s_ib2;
    logic [3:0]     s_clamp;

    t_item           r_m1_item;
    logic [2*QB-1:0] r_m1_p3a;
    logic [2*QB-1:0] r_m1_p3b;
    logic [QB-1:0]   r_m1_ia1;
    logic [QB-1:0]   r_m1_ib1;
    logic            r_m1_flag;
    logic signed [W-1:0] r_m1_xx;
    logic signed [W-1:0] r_m1_yy;
    logic signed [W-1:0] r_m1_vxx;
    logic signed [W-1:0] r_m1_vyy;
    logic signed [W-1:0] r_m1_vzz;

    logic [2*QB-1:0] s_t3a;
    logic [2*QB-1:0] s_t3b;

    t_item                r_m2_item;
    logic [QB-1:0]        r_m2_ia3;
    logic [QB-1:0]        r_m2_ib3;
    logic                 r_m2_flag;
    logic signed [W-1:0]  r_m2_ua;
    logic signed [W-1:0]  r_m2_ub;
    logic signed [MW-1:0] r_m2_sxy;
    logic signed [MW-1:0] r_m2_vsum;

    t_item                r_m3_item;
    logic signed [W-1:0]  r_m3_g1;
    logic signed [W-1:0]  r_m3_g2;
    logic                 r_m3_flag;
    logic signed [W-1:0]  r_m3_ua;
    logic signed [W-1:0]  r_m3_ub;
    logic signed [MW-1:0] r_m3_sxy;
    logic signed [MW-1:0] r_m3_vsum;

    t_item                r_m4_item;
    logic signed [W-1:0]  r_m4_t1;
    logic signed [W-1:0]  r_m4_t2;
    logic signed [W-1:0]  r_m4_t3;
    logic signed [W-1:0]  r_m4_t4;
    logic signed [W-1:0]  r_m4_t5;
    logic signed [W-1:0]  r_m4_t6;
    logic                 r_m4_flag;
    logic signed [W-1:0]  r_m4_ua;
    logic signed [W-1:0]  r_m4_ub;
    logic signed [MW-1:0] r_m4_sxy;
    logic signed [MW-1:0] r_m4_vsum;

    t_item                r_m5_item;
    logic signed [W-1:0]  r_m5_ax;
    logic signed [W-1:0]  r_m5_ay;
    logic signed [W-1:0]  r_m5_az;
    logic signed [W-1:0]  r_m5_u;
    logic                 r_m5_flag;
    logic signed [MW-1:0] r_m5_vsum;

    logic signed [W-1:0]  r_out_dx;
    logic signed [W-1:0]  r_out_dy;
    logic signed [W-1:0]  r_out_dz;
    logic signed [W-1:0]  r_out_ax;
    logic signed [W-1:0]  r_out_ay;
    logic signed [W-1:0]  r_out_az;
    logic signed [W-1:0]  r_out_u;
    logic signed [W-1:0]  r_out_c;
    logic                 r_out_flag;

    assign s_head  = t_item'(i_q_data);
    assign o_q_pop = i_q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], i_q_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_s0_item <= s_head;
        r_s0_sq1  <= (2*W)'(mag(s_head.dx1)) * (2*W)'(mag(s_head.dx1));
        r_s0_sq2  <= (2*W)'(mag(s_head.dx2)) * (2*W)'(mag(s_head.dx2));
        r_s0_sqy  <= (2*W)'(mag(s_head.y)) * (2*W)'(mag(s_head.y));
        r_s0_sqz  <= (2*W)'(mag(s_head.z)) * (2*W)'(mag(s_head.z));

        r_s1_item <= r_s0_item;
        r_s1_d2a  <= r_s0_sq1 + r_s0_sqy + r_s0_sqz;
        r_s1_d2b  <= r_s0_sq2 + r_s0_sqy + r_s0_sqz;
    end

    c3d_isqrt #(.WORD_BITS(W)) u_sqrt_a (.i_clk(i_clk), .i_rad(r_s1_d2a), .o_root(s_ra));
    c3d_isqrt #(.WORD_BITS(W)) u_sqrt_b (.i_clk(i_clk), .i_rad(r_s1_d2b), .o_root(s_rb));

    c3d_delay #(.DATA_BITS(4*W), .DEPTH(W)) u_d2_dly (
        .i_clk (i_clk),
        .i_data({r_s1_d2a, r_s1_d2b}),
        .o_data(s_d2_dly)
    );

    c3d_delay #(.DATA_BITS($bits(t_item)), .DEPTH(DLY)) u_item_dly (
        .i_clk (i_clk),
        .i_data(r_s1_item),
        .o_data(s_r_item)
    );

    c3d_recip #(.WORD_BITS(W), .NUM_EXP(2*F), .DEN_BITS(W)) u_inv1_a (
        .i_clk(i_clk), .i_den(s_ra), .o_quo(s_ia1), .o_clamp(s_clamp[0])
    );
    c3d_recip #(.WORD_BITS(W), .NUM_EXP(2*F), .DEN_BITS(W)) u_inv1_b (
        .i_clk(i_clk), .i_den(s_rb), .o_quo(s_ib1), .o_clamp(s_clamp[1])
    );
    c3d_recip #(.WORD_BITS(W), .NUM_EXP(3*F), .DEN_BITS(2*W)) u_inv2_a (
        .i_clk(i_clk), .i_den(s_d2_dly[4*W-1:2*W]), .o_quo(s_ia2), .o_clamp(s_clamp[2])
    );
    c3d_recip #(.WORD_BITS(W), .NUM_EXP(3*F), .DEN_BITS(2*W)) u_inv2_b (
        .i_clk(i_clk), .i_den(s_d2_dly[2*W-1:0]), .o_quo(s_ib2), .o_clamp(s_clamp[3])
    );

    // inverse cube before the cap
    assign s_t3a = r_m1_p3a >> F;
    assign s_t3b = r_m1_p3b >> F;

    always_ff @(posedge i_clk) begin
        r_m1_item <= s_r_item;
        r_m1_p3a  <= (2*QB)'(s_ia2) * (2*QB)'(s_ia1);
        r_m1_p3b  <= (2*QB)'(s_ib2) * (2*QB)'(s_ib1);
        r_m1_ia1  <= s_ia1;
        r_m1_ib1  <= s_ib1;
        r_m1_flag <= |s_clamp;
        r_m1_xx   <= mulq(s_r_item.x, s_r_item.x);
        r_m1_yy   <= mulq(s_r_item.y, s_r_item.y);
        r_m1_vxx  <= mulq(s_r_item.vx, s_r_item.vx);
        r_m1_vyy  <= mulq(s_r_item.vy, s_r_item.vy);
        r_m1_vzz  <= mulq(s_r_item.vz, s_r_item.vz);

        r_m2_item <= r_m1_item;
        r_m2_ia3  <= (s_t3a[2*QB-1:QB] != '0) ? '1 : s_t3a[QB-1:0];
        r_m2_ib3  <= (s_t3b[2*QB-1:QB] != '0) ? '1 : s_t3b[QB-1:0];
        r_m2_flag <= r_m1_flag || (s_t3a[2*QB-1:QB] != '0) || (s_t3b[2*QB-1:QB] != '0);
        r_m2_ua   <= mulq(r_m1_item.om, $signed({1'b0, r_m1_ia1}));
        r_m2_ub   <= mulq(r_m1_item.mu, $signed({1'b0, r_m1_ib1}));
        r_m2_sxy  <= (ext(r_m1_xx) + ext(r_m1_yy)) >>> 1;
        r_m2_vsum <= ext(r_m1_vxx) + ext(r_m1_vyy) + ext(r_m1_vzz);

        r_m3_item <= r_m2_item;
        r_m3_g1   <= mulq(r_m2_item.om, $signed({1'b0, r_m2_ia3}));
        r_m3_g2   <= mulq(r_m2_item.mu, $signed({1'b0, r_m2_ib3}));
        r_m3_flag <= r_m2_flag;
        r_m3_ua   <= r_m2_ua;
        r_m3_ub   <= r_m2_ub;
        r_m3_sxy  <= r_m2_sxy;
        r_m3_vsum <= r_m2_vsum;

        r_m4_item <= r_m3_item;
        r_m4_t1   <= mulq(r_m3_g1, r_m3_item.dx1);
        r_m4_t2   <= mulq(r_m3_g2, r_m3_item.dx2);
        r_m4_t3   <= mulq(r_m3_g1, r_m3_item.y);
        r_m4_t4   <= mulq(r_m3_g2, r_m3_item.y);
        r_m4_t5   <= mulq(r_m3_g1, r_m3_item.z);
        r_m4_t6   <= mulq(r_m3_g2, r_m3_item.z);
        r_m4_flag <= r_m3_flag;
        r_m4_ua   <= r_m3_ua;
        r_m4_ub   <= r_m3_ub;
        r_m4_sxy  <= r_m3_sxy;
        r_m4_vsum <= r_m3_vsum;

        r_m5_item <= r_m4_item;
        r_m5_ax   <= sat_m(ext(r_m4_item.x) - ext(r_m4_t1) - ext(r_m4_t2)
                           + ext(r_m4_item.vy) + ext(r_m4_item.vy));
        r_m5_ay   <= sat_m(ext(r_m4_item.y) - ext(r_m4_t3) - ext(r_m4_t4)
                           - ext(r_m4_item.vx) - ext(r_m4_item.vx));
        r_m5_az   <= r_m4_item.sp ? sat_m(-ext(r_m4_t5) - ext(r_m4_t6)) : '0;
        r_m5_u    <= sat_m(ext(r_m4_ua) + ext(r_m4_ub) + r_m4_sxy);
        r_m5_flag <= r_m4_flag;
        r_m5_vsum <= r_m4_vsum;

        r_out_dx   <= r_m5_item.vx;
        r_out_dy   <= r_m5_item.vy;
        r_out_dz   <= r_m5_item.vz;
        r_out_ax   <= r_m5_ax;
        r_out_ay   <= r_m5_ay;
        r_out_az   <= r_m5_az;
        r_out_u    <= r_m5_u;
        r_out_c    <= sat_m(ext(r_m5_u) + ext(r_m5_u) - r_m5_vsum);
        r_out_flag <= r_m5_flag;
    end

    assign o_done                = r_vld[LAT-1];
    assign o_dpos_x              = r_out_dx;
    assign o_dpos_y              = r_out_dy;
    assign o_dpos_z              = r_out_dz;
    assign o_accel_x             = r_out_ax;
    assign o_accel_y             = r_out_ay;
    assign o_accel_z             = r_out_az;
    assign o_effective_potential = r_out_u;
    assign o_jacobi_constant     = r_out_c;
    assign o_near_singular       = r_out_flag;

endmodule

`default_nettype wire

// ===== dv/tb_cr3bp_state_derivative_core.sv =====
// ============================================================================
// tb_cr3bp_state_derivative_core: self-checking bench for the CR3BP core
// Drives random and directed rotating-frame states through the command port,
// predicts each derivative with a wide-integer model of the equations of
// motion, and checks every strobed result in order, across several register
// settings and sender idle rates.
// ============================================================================
`default_nettype none

module tb_cr3bp_state_derivative_core;
    import c3d_pkg::*;

    localparam int W       = 32;
    localparam int FB      = 24;
    localparam int LATENCY = 2 * W + 8;

    typedef logic signed [127:0] t_wide;
    typedef logic signed [W-1:0] t_word;

    localparam t_wide WMAX = 128'sh7fff_ffff;
    localparam t_wide WMIN = -128'sh8000_0000;
    localparam t_wide QONE = 128'sd16777216;

    typedef struct packed {
        t_word px, py, pz, vx, vy, vz;
    } t_state;

    typedef struct packed {
        t_word dx, dy, dz, ax, ay, az, pot, jac;
        logic  sing;
    } t_deriv;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_word       i_pos_x, i_pos_y, i_pos_z, i_vel_x_in, i_vel_y_in, i_vel_z_in;
    logic        o_done;
    t_word       o_dpos_x, o_dpos_y, o_dpos_z, o_accel_x, o_accel_y, o_accel_z;
    t_word       o_effective_potential, o_jacobi_constant;
    logic        o_near_singular;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index;
    logic [CFG_DATA_BITS-1:0] i_cfg_data;

    cr3bp_state_derivative_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_pos_x(i_pos_x), .i_pos_y(i_pos_y), .i_pos_z(i_pos_z),
        .i_vel_x_in(i_vel_x_in), .i_vel_y_in(i_vel_y_in), .i_vel_z_in(i_vel_z_in),
        .o_done(o_done), .o_dpos_x(o_dpos_x), .o_dpos_y(o_dpos_y),
        .o_dpos_z(o_dpos_z), .o_accel_x(o_accel_x), .o_accel_y(o_accel_y),
        .o_accel_z(o_accel_z), .o_effective_potential(o_effective_potential),
        .o_jacobi_constant(o_jacobi_constant), .o_near_singular(o_near_singular),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // register copies used by the predictor
    logic [MU_BITS-1:0] mass_ratio_q;
    t_word              prim1_x_q, prim2_x_q;
    logic               spatial_q;

    t_state state_q[$];
    t_deriv deriv_q[$];
    int     idle_pct;
    int     n_err, n_taken, n_checked, n_sing;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_word sat_word(input t_wide s);
        if (s > WMAX) return t_word'(WMAX);
        if (s < WMIN) return t_word'(WMIN);
        return s[W-1:0];
    endfunction

    // Q-format product, truncated toward zero, saturated
    function automatic t_word qmul(input t_word a, input t_word b);
        t_wide p, q;
        p = a;
        q = b;
        p = (p * q) / QONE;
        return sat_word(p);
    endfunction

    function automatic logic [127:0] int_sqrt(input logic [127:0] n);
        logic [127:0] res, bitv;
        res  = '0;
        bitv = 128'd1 << 126;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [127:0] clamp_pos(input logic [127:0] q, inout logic flag);
        if (q > 128'h7fff_ffff) begin
            flag = 1'b1;
            return 128'h7fff_ffff;
        end
        return q;
    endfunction

    function automatic logic [127:0] div_clamp(input logic [127:0] num,
                                               input logic [127:0] den, inout logic flag);
        if (den == 0) begin
            flag = 1'b1;
            return 128'h7fff_ffff;
        end
        return clamp_pos(num / den, flag);
    endfunction

    // 1/r and 1/r^3 toward one primary
    function automatic void primary_inverses(input t_word dx, input t_word y, input t_word z,
                                             output t_word inv1, output t_word inv3,
                                             inout logic flag);
        t_wide a, b, c;
        logic [127:0] d2, r, i1, i2, i3;
        a  = dx;
        b  = y;
        c  = z;
        d2 = a * a + b * b + c * c;
        r  = int_sqrt(d2);
        i1 = div_clamp(128'd1 << (2 * FB), r, flag);
        i2 = div_clamp(128'd1 << (3 * FB), d2, flag);
        i3 = clamp_pos((i2 * i1) >> FB, flag);
        inv1 = i1[W-1:0];
        inv3 = i3[W-1:0];
    endfunction

    function automatic t_deriv eval_derivative(input t_state s);
        t_deriv d;
        t_word  x, y, z, vx, vy, vz, mu, om, dx1, dx2;
        t_word  ia1, ia3, ib1, ib3, g1, g2;
        t_wide  acc;
        logic   flag;
        flag = 1'b0;
        x  = s.px;
        y  = s.py;
        vx = s.vx;
        vy = s.vy;
        z  = spatial_q ? s.pz : '0;
        vz = spatial_q ? s.vz : '0;
        mu = t_word'({8'd0, mass_ratio_q});
        om = t_word'(QONE) - mu;
        dx1 = sat_word(t_wide'(x) - t_wide'(prim1_x_q));
        dx2 = sat_word(t_wide'(x) - t_wide'(prim2_x_q));
        primary_inverses(dx1, y, z, ia1, ia3, flag);
        primary_inverses(dx2, y, z, ib1, ib3, flag);
        g1 = qmul(om, ia3);
        g2 = qmul(mu, ib3);
        d.dx = vx;
        d.dy = vy;
        d.dz = vz;
        acc  = t_wide'(x) - t_wide'(qmul(g1, dx1)) - t_wide'(qmul(g2, dx2))
             + t_wide'(vy) + t_wide'(vy);
        d.ax = sat_word(acc);
        acc  = t_wide'(y) - t_wide'(qmul(g1, y)) - t_wide'(qmul(g2, y))
             - t_wide'(vx) - t_wide'(vx);
        d.ay = sat_word(acc);
        acc  = -t_wide'(qmul(g1, z)) - t_wide'(qmul(g2, z));
        d.az = spatial_q ? sat_word(acc) : '0;
        acc  = (t_wide'(qmul(x, x)) + t_wide'(qmul(y, y))) >>> 1;
        d.pot = sat_word(t_wide'(qmul(om, ia1)) + t_wide'(qmul(mu, ib1)) + acc);
        acc  = t_wide'(qmul(vx, vx)) + t_wide'(qmul(vy, vy)) + t_wide'(qmul(vz, vz));
        d.jac = sat_word(t_wide'(d.pot) + t_wide'(d.pot) - acc);
        d.sing = flag;
        return d;
    endfunction

    task automatic report_mismatch(input string what, input t_word got, input t_word want);
        $display("MISMATCH result %0d %s: got %h expected %h", n_checked, what, got, want);
        n_err++;
    endtask

    task automatic add_state(input t_state s);
        state_q.insert(state_q.size(), s);
    endtask

    // driver: one beat per edge with start high and busy low
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                deriv_q.insert(deriv_q.size(), eval_derivative(state_q[0]));
                void'(state_q.pop_front());
                n_taken++;
            end
            if (state_q.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
                start      <= 1'b1;
                i_pos_x    <= state_q[0].px;
                i_pos_y    <= state_q[0].py;
                i_pos_z    <= state_q[0].pz;
                i_vel_x_in <= state_q[0].vx;
                i_vel_y_in <= state_q[0].vy;
                i_vel_z_in <= state_q[0].vz;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_deriv e;
        if (i_rst_n && o_done) begin
            if (deriv_q.size() == 0) begin
                $display("UNEXPECTED result with nothing pending");
                n_err++;
            end else begin
                e = deriv_q.pop_front();
                if (o_dpos_x !== e.dx) report_mismatch("dpos_x", o_dpos_x, e.dx);
                if (o_dpos_y !== e.dy) report_mismatch("dpos_y", o_dpos_y, e.dy);
                if (o_dpos_z !== e.dz) report_mismatch("dpos_z", o_dpos_z, e.dz);
                if (o_accel_x !== e.ax) report_mismatch("accel_x", o_accel_x, e.ax);
                if (o_accel_y !== e.ay) report_mismatch("accel_y", o_accel_y, e.ay);
                if (o_accel_z !== e.az) report_mismatch("accel_z", o_accel_z, e.az);
                if (o_effective_potential !== e.pot)
                    report_mismatch("potential", o_effective_potential, e.pot);
                if (o_jacobi_constant !== e.jac)
                    report_mismatch("jacobi", o_jacobi_constant, e.jac);
                if (o_near_singular !== e.sing)
                    report_mismatch("near_singular", t_word'(o_near_singular), t_word'(e.sing));
                if (e.sing) n_sing++;
                n_checked++;
            end
        end
    end

    // one write beat; valid is dropped again before the next write
    task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_MASS_RATIO:    mass_ratio_q = data[MU_BITS-1:0];
            CFG_PRIMARY_ONE_X: prim1_x_q    = data;
            CFG_PRIMARY_TWO_X: prim2_x_q    = data;
            CFG_SPATIAL_MODE:  spatial_q    = data[0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_regs(input logic [31:0] mu, input logic [31:0] p1,
                            input logic [31:0] p2, input logic sp);
        cfg_write(CFG_MASS_RATIO, mu);
        cfg_write(CFG_PRIMARY_ONE_X, p1);
        cfg_write(CFG_PRIMARY_TWO_X, p2);
        cfg_write(CFG_SPATIAL_MODE, {31'd0, sp});
    endtask

    // sender pauses here until every pending result is back
    task automatic drain();
        while (state_q.size() != 0 || deriv_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
    endtask

    function automatic t_word mid_word();
        return t_word'($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000;
    endfunction

    function automatic t_word any_word();
        case ($urandom_range(0, 3))
            0: return t_word'($urandom());
            1: return 32'sh7fff_ffff;
            2: return -32'sh8000_0000;
            default: return mid_word();
        endcase
    endfunction

    function automatic t_state random_state();
        t_state s;
        t_word  p;
        s = '{mid_word(), mid_word(), mid_word(), mid_word(), mid_word(), mid_word()};
        case ($urandom_range(0, 9))
            0, 1: s = '{t_word'($urandom()), t_word'($urandom()), t_word'($urandom()),
                        t_word'($urandom()), t_word'($urandom()), t_word'($urandom())};
            2: s = '{any_word(), any_word(), any_word(), any_word(), any_word(), any_word()};
            3, 4: begin
                // close approach to a primary
                p = $urandom_range(0, 1) ? prim1_x_q : prim2_x_q;
                s.px = p + t_word'($urandom_range(0, 4096)) - 32'sd2048;
                s.py = t_word'($urandom_range(0, 4096)) - 32'sd2048;
                s.pz = t_word'($urandom_range(0, 64)) - 32'sd32;
            end
            default: ;
        endcase
        return s;
    endfunction

    task automatic run_random(input int n, input int idle);
        idle_pct = idle;
        repeat (n) add_state(random_state());
        drain();
    endtask

    initial begin
        t_word mx, mn;
        mx = 32'sh7fff_ffff;
        mn = -32'sh8000_0000;
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_pos_x     <= '0;
        i_pos_y     <= '0;
        i_pos_z     <= '0;
        i_vel_x_in  <= '0;
        i_vel_y_in  <= '0;
        i_vel_z_in  <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        mass_ratio_q = MU_RST;
        prim1_x_q    = P1_RST;
        prim2_x_q    = P2_RST;
        spatial_q    = SP_RST;
        idle_pct     = 0;
        n_err = 0; n_taken = 0; n_checked = 0; n_sing = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: origin, both primaries exactly, field extremes, unit states
        add_state('{32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0});
        add_state('{prim1_x_q, 32'sd0, 32'sd0, 32'sd1, -32'sd1, 32'sd0});
        add_state('{prim2_x_q, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd5});
        add_state('{prim2_x_q + 1, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0});
        add_state('{prim1_x_q, 32'sd1, 32'sd0, 32'sd0, 32'sd0, 32'sd0});
        add_state('{mx, mx, mx, mx, mx, mx});
        add_state('{mn, mn, mn, mn, mn, mn});
        add_state('{mx, mn, mx, mn, mx, mn});
        add_state('{mn, mx, mn, mx, mn, mx});
        add_state('{32'sh0100_0000, 32'sd0, 32'sd0, 32'sd0, 32'sh0100_0000, 32'sd0});
        add_state('{32'sh00e0_0000, 32'sh0010_0000, 32'sh0020_0000,
                    32'sd0, 32'sh0008_0000, -32'sh0004_0000});
        add_state('{-32'sh0100_0000, 32'sh0100_0000, -32'sh0100_0000,
                    32'sh0200_0000, -32'sh0200_0000, 32'sh0100_0000});
        add_state('{32'sd0, mx, 32'sd0, 32'sd0, 32'sd0, mn});
        add_state('{32'sd0, 32'sd0, mn, 32'sd0, 32'sd0, 32'sd0});
        add_state('{-32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1});
        drain();
        run_random(85, 0);

        cfg_write(CFG_SPATIAL_MODE, 32'd0);
        add_state('{mx, mn, mx, mn, mx, mn});
        add_state('{prim1_x_q, 32'sd0, mx, 32'sd0, 32'sd0, mx});
        run_random(85, 50);

        set_regs(32'd0, 32'd0, 32'h0100_0000, 1'b1);
        run_random(85, 35);

        set_regs(32'h0080_0000, 32'h8000_0000, 32'h7fff_ffff, 1'b0);
        run_random(85, 0);

        set_regs(32'h0080_0000, 32'hff80_0000, 32'h0080_0000, 1'b1);
        run_random(85, 50);

        set_regs($urandom_range(0, 32'h0080_0000), $urandom(), $urandom(), 1'b1);
        run_random(85, 35);

        $display("Checked %0d of %0d states over six register settings; %0d near-singular.",
                 n_checked, n_taken, n_sing);
        if (n_err == 0) begin
            $display("cr3bp_state_derivative_core test passed");
        end else begin
            $display("cr3bp_state_derivative_core test failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Timeout with %0d results pending", deriv_q.size());
        $display("cr3bp_state_derivative_core test failed");
        $finish;
    end

endmodule

`default_nettype wire
